@@ design/gws_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and neighbor offsets for the gradient stencil.
package gws_pkg;

  localparam int unsigned MaxRows      = 64;
  localparam int unsigned MaxCols      = 64;
  localparam int unsigned MinNeighbors = 3;
  localparam int unsigned RowW         = 6;
  localparam int unsigned ColW         = 6;
  localparam int unsigned AddrW        = RowW + ColW;
  localparam int unsigned Depth        = MaxRows * MaxCols;
  localparam int unsigned DataW        = 32;
  localparam int unsigned CfgW         = 7;
  localparam int unsigned PAddrW       = 3;
  localparam int unsigned RamW         = 4 * DataW + 1;
  localparam int unsigned MulBW        = DataW + 3;
  localparam int unsigned DivBits      = 32;

  localparam logic ActWrite    = 1'b0;
  localparam logic ActCompute  = 1'b1;
  localparam logic CfgGridRows = 1'b0;
  localparam logic CfgGridCols = 1'b1;

  localparam logic signed [1:0] OffNeg  = 2'sb11;
  localparam logic signed [1:0] OffZero = 2'sb00;
  localparam logic signed [1:0] OffPos  = 2'sb01;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic        big;
    logic [30:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic signed [1:0] di;
    logic signed [1:0] dj;
  } nb_off_t;

  function automatic nb_off_t nb_offset(input logic [2:0] k);
    nb_off_t o;
    unique case (k)
      3'd0: o = '{di: OffNeg,  dj: OffNeg};
      3'd1: o = '{di: OffNeg,  dj: OffZero};
      3'd2: o = '{di: OffNeg,  dj: OffPos};
      3'd3: o = '{di: OffZero, dj: OffNeg};
      3'd4: o = '{di: OffZero, dj: OffPos};
      3'd5: o = '{di: OffPos,  dj: OffNeg};
      3'd6: o = '{di: OffPos,  dj: OffZero};
      default: o = '{di: OffPos, dj: OffPos};
    endcase
    return o;
  endfunction

endpackage

@@ design/gws_in_if.sv @@
`timescale 1ns / 1ps
// Request channel carrying cell writes and gradient computes.
interface gws_in_if;
  import gws_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [RowW-1:0]         row;
  logic [ColW-1:0]         col;
  logic signed [DataW-1:0] center_r;
  logic signed [DataW-1:0] center_z;
  logic [DataW-1:0]        cell_size;
  logic signed [DataW-1:0] value;
  logic                    interface_req;

  modport source (
    output valid, action, row, col, center_r, center_z, cell_size, value, interface_req,
    input  ready
  );

  modport sink (
    input  valid, action, row, col, center_r, center_z, cell_size, value, interface_req,
    output ready
  );
endinterface

@@ design/gws_out_if.sv @@
`timescale 1ns / 1ps
// Result channel carrying the solved gradient.
interface gws_out_if;
  import gws_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] grad_r;
  logic signed [DataW-1:0] grad_z;
  logic                    available;

  modport source (output valid, grad_r, grad_z, available, input ready);
  modport sink (input valid, grad_r, grad_z, available, output ready);
endinterface

@@ design/grid_wls_gradient_stencil.sv @@
`timescale 1ns / 1ps
// Top level: cell store, APB registers and the stencil sequencer.
//
//  channel  | direction | handshake     | payload
//  ---------+-----------+---------------+-----------------------------------------
//  in_i     | in        | valid/ready   | action, row, col, center, size, value, flag
//  out_o    | out       | valid/ready   | grad_r, grad_z, available
//  apb      | in        | psel/penable  | paddr, pwdata, prdata (pready always high)
//
// A write item is stored as it is taken. A compute item loads the center cell,
// then per in-grid, unflagged neighbor reads the cell and runs five multiplies and
// five divisions, plus six multiplies and two divisions to solve. The shared
// one-bit-a-cycle divider dominates the run time. Reset clears the sequencer
// and sets both grid sizes to 64; the cell store is not cleared. A waiting result
// does not block the next request; the sequencer holds in its output state only.
module grid_wls_gradient_stencil (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  gws_in_if.sink                     in_i,
  gws_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gws_pkg::PAddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import gws_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StCLoad = 4'd1;
  localparam logic [3:0] StNSel  = 4'd2;
  localparam logic [3:0] StNLoad = 4'd3;
  localparam logic [3:0] StMul   = 4'd4;
  localparam logic [3:0] StMulW  = 4'd5;
  localparam logic [3:0] StD2    = 4'd6;
  localparam logic [3:0] StDiv   = 4'd7;
  localparam logic [3:0] StDivW  = 4'd8;
  localparam logic [3:0] StDet   = 4'd9;
  localparam logic [3:0] StGDiv  = 4'd10;
  localparam logic [3:0] StGDivW = 4'd11;
  localparam logic [3:0] StOut   = 4'd12;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  // configuration
  logic [CfgW-1:0] grid_rows_q, grid_rows_d;
  logic [CfgW-1:0] grid_cols_q, grid_cols_d;
  logic [CfgW-1:0] rows_eff, cols_eff;
  logic            cfg_we;

  // control
  logic [3:0] state_q, state_d;
  logic [3:0] k_q, k_d;
  logic [2:0] step_q, step_d;
  logic       fin_q, fin_d;
  logic [3:0] cnt_q, cnt_d;
  logic       ok_q, ok_d;
  logic       out_valid_q, out_valid_d;

  // payload
  logic [RowW-1:0]    row_q, row_d;
  logic [ColW-1:0]    col_q, col_d;
  logic signed [31:0] rc_q, rc_d, zc_q, zc_d, vc_q, vc_d;
  logic               flagc_q, flagc_d;
  logic signed [31:0] dr_q, dr_d, dz_q, dz_d, dq_q, dq_d;
  logic signed [63:0] mprod_q [6];
  logic signed [63:0] mprod_d [6];
  logic [63:0]        d2_q, d2_d;
  logic [19:0]        srr_q, srr_d, szz_q, szz_d;
  logic signed [19:0] srz_q, srz_d;
  logic signed [35:0] pr_q, pr_d, pz_q, pz_d;
  logic signed [63:0] det_q, det_d, nr_q, nr_d, nz_q, nz_d;
  logic signed [31:0] gr_q, gr_d, gz_q, gz_d;
  logic signed [31:0] ograd_r_q, ograd_r_d, ograd_z_q, ograd_z_d;
  logic               oavail_q, oavail_d;

  // store
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [RamW-1:0]  ram_wdata, ram_rdata;
  logic signed [31:0] rd_r, rd_z, rd_v;
  logic             rd_flag;

  // shared units
  logic [DataW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic             mul_neg;
  logic [63:0]      mul_p;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // neighbor address
  nb_off_t          off;
  logic [7:0]       ni, nj;
  logic             nb_in;

  logic             in_acc;
  logic             out_acc;
  logic [31:0]      adr, adz, adq;
  logic [19:0]      asrz;
  logic [35:0]      apr, apz;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = {25'b0, (paddr[PAddrW-1] == CfgGridRows) ? grid_rows_q : grid_cols_q};

  always_comb begin
    grid_rows_d = grid_rows_q;
    grid_cols_d = grid_cols_q;
    if (cfg_we) begin
      if (paddr[PAddrW-1] == CfgGridRows) begin
        grid_rows_d = pwdata[CfgW-1:0];
      end else begin
        grid_cols_d = pwdata[CfgW-1:0];
      end
    end
  end

  assign rows_eff = (grid_rows_q > CfgW'(MaxRows)) ? CfgW'(MaxRows) : grid_rows_q;
  assign cols_eff = (grid_cols_q > CfgW'(MaxCols)) ? CfgW'(MaxCols) : grid_cols_q;

  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;

  assign off   = nb_offset(k_q[2:0]);
  assign ni    = {2'b00, row_q} + {{6{off.di[1]}}, off.di};
  assign nj    = {2'b00, col_q} + {{6{off.dj[1]}}, off.dj};
  assign nb_in = !ni[7] && (ni[6:0] < rows_eff) && !nj[7] && (nj[6:0] < cols_eff);

  assign ram_we    = in_acc && (in_i.action == ActWrite);
  assign ram_waddr = {in_i.row, in_i.col};
  assign ram_wdata = {in_i.interface_req, in_i.value, in_i.cell_size, in_i.center_z,
                      in_i.center_r};
  assign ram_raddr = (state_q == StIdle) ? {in_i.row, in_i.col} : {ni[RowW-1:0], nj[ColW-1:0]};

  assign rd_r    = ram_rdata[DataW-1:0];
  assign rd_z    = ram_rdata[2*DataW-1:DataW];
  assign rd_v    = ram_rdata[4*DataW-1:3*DataW];
  assign rd_flag = ram_rdata[4*DataW];

  gws_ram #(.Width(RamW), .Depth(Depth)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign adr  = mag32(dr_q);
  assign adz  = mag32(dz_q);
  assign adq  = mag32(dq_q);
  assign asrz = srz_q[19] ? 20'(-srz_q) : 20'(srz_q);
  assign apr  = pr_q[35] ? 36'(-pr_q) : 36'(pr_q);
  assign apz  = pz_q[35] ? 36'(-pz_q) : 36'(pz_q);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    if (!fin_q) begin
      unique case (step_q)
        3'd0: begin mul_a = adr; mul_b = {3'b0, adr}; end
        3'd1: begin mul_a = adz; mul_b = {3'b0, adz}; end
        3'd2: begin mul_a = adr; mul_b = {3'b0, adz}; end
        3'd3: begin mul_a = adr; mul_b = {3'b0, adq}; end
        3'd4: begin mul_a = adz; mul_b = {3'b0, adq}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      unique case (step_q)
        3'd0: begin mul_a = {12'b0, srr_q}; mul_b = {15'b0, szz_q}; end
        3'd1: begin mul_a = {12'b0, asrz};  mul_b = {15'b0, asrz}; end
        3'd2: begin
          mul_a = {12'b0, szz_q}; mul_b = apr[MulBW-1:0]; mul_neg = pr_q[35];
        end
        3'd3: begin
          mul_a = {12'b0, asrz}; mul_b = apz[MulBW-1:0]; mul_neg = srz_q[19] ^ pz_q[35];
        end
        3'd4: begin
          mul_a = {12'b0, srr_q}; mul_b = apz[MulBW-1:0]; mul_neg = pz_q[35];
        end
        3'd5: begin
          mul_a = {12'b0, asrz}; mul_b = apr[MulBW-1:0]; mul_neg = srz_q[19] ^ pr_q[35];
        end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  gws_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  always_comb begin
    div_req.start = (state_q == StDiv) || (state_q == StGDiv);
    if (state_q == StDiv) begin
      div_req.num = mprod_q[step_q];
      div_req.den = d2_q;
    end else begin
      div_req.num = step_q[0] ? mag64(nz_q) : mag64(nr_q);
      div_req.den = mag64(det_q);
    end
  end

  gws_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    logic signed [32:0] ddr, ddz, ddq;
    logic signed [63:0] det_c;
    logic [31:0]        gq;
    logic               gneg;

    state_d     = state_q;
    k_d         = k_q;
    step_d      = step_q;
    fin_d       = fin_q;
    cnt_d       = cnt_q;
    ok_d        = ok_q;
    out_valid_d = out_acc ? 1'b0 : out_valid_q;
    row_d       = row_q;
    col_d       = col_q;
    rc_d        = rc_q;
    zc_d        = zc_q;
    vc_d        = vc_q;
    flagc_d     = flagc_q;
    dr_d        = dr_q;
    dz_d        = dz_q;
    dq_d        = dq_q;
    mprod_d     = mprod_q;
    d2_d        = d2_q;
    srr_d       = srr_q;
    szz_d       = szz_q;
    srz_d       = srz_q;
    pr_d        = pr_q;
    pz_d        = pz_q;
    det_d       = det_q;
    nr_d        = nr_q;
    nz_d        = nz_q;
    gr_d        = gr_q;
    gz_d        = gz_q;
    ograd_r_d   = ograd_r_q;
    ograd_z_d   = ograd_z_q;
    oavail_d    = oavail_q;

    ddr   = {rd_r[31], rd_r} - {rc_q[31], rc_q};
    ddz   = {rd_z[31], rd_z} - {zc_q[31], zc_q};
    ddq   = {rd_v[31], rd_v} - {vc_q[31], vc_q};
    det_c = mprod_q[0] - mprod_q[1];
    gq    = {1'b0, div_rsp.quo};
    gneg  = step_q[0] ? (nz_q[63] ^ det_q[63]) : (nr_q[63] ^ det_q[63]);

    unique case (state_q)
      StIdle: begin
        if (in_acc && (in_i.action == ActCompute)) begin
          row_d  = in_i.row;
          col_d  = in_i.col;
          k_d    = '0;
          cnt_d  = '0;
          fin_d  = 1'b0;
          ok_d   = 1'b0;
          srr_d  = '0;
          szz_d  = '0;
          srz_d  = '0;
          pr_d   = '0;
          pz_d   = '0;
          if (({1'b0, in_i.row} < rows_eff) && ({1'b0, in_i.col} < cols_eff)) begin
            state_d = StCLoad;
          end else begin
            state_d = StOut;
          end
        end
      end
      StCLoad: begin
        rc_d    = rd_r;
        zc_d    = rd_z;
        vc_d    = rd_v;
        flagc_d = rd_flag;
        state_d = StNSel;
      end
      StNSel: begin
        if (k_q == 4'd8) begin
          if (cnt_q < 4'(MinNeighbors)) begin
            state_d = StOut;
          end else begin
            fin_d   = 1'b1;
            step_d  = '0;
            state_d = StMul;
          end
        end else if (nb_in) begin
          state_d = StNLoad;
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      StNLoad: begin
        if (flagc_q || rd_flag) begin
          k_d     = k_q + 4'd1;
          state_d = StNSel;
        end else if ((ddr[32] != ddr[31]) || (ddz[32] != ddz[31]) || (ddq[32] != ddq[31])) begin
          state_d = StOut;
        end else begin
          dr_d    = ddr[31:0];
          dz_d    = ddz[31:0];
          dq_d    = ddq[31:0];
          step_d  = '0;
          state_d = StMul;
        end
      end
      StMul: begin
        state_d = StMulW;
      end
      StMulW: begin
        mprod_d[step_q] = mul_neg ? 64'(-mul_p) : mul_p;
        if (fin_q && (step_q == 3'd5)) begin
          state_d = StDet;
        end else if (!fin_q && (step_q == 3'd4)) begin
          state_d = StD2;
        end else begin
          step_d  = step_q + 3'd1;
          state_d = StMul;
        end
      end
      StD2: begin
        d2_d    = mprod_q[0] + mprod_q[1] + 64'd1;
        step_d  = '0;
        state_d = StDiv;
      end
      StDiv: begin
        state_d = StDivW;
      end
      StDivW: begin
        if (div_rsp.done) begin
          unique case (step_q)
            3'd0: srr_d = srr_q + div_rsp.quo[19:0];
            3'd1: szz_d = szz_q + div_rsp.quo[19:0];
            3'd2: srz_d = (dr_q[31] ^ dz_q[31]) ? srz_q - $signed({1'b0, div_rsp.quo[18:0]})
                                                : srz_q + $signed({1'b0, div_rsp.quo[18:0]});
            3'd3: pr_d = (dr_q[31] ^ dq_q[31]) ? pr_q - $signed({5'b0, div_rsp.quo})
                                               : pr_q + $signed({5'b0, div_rsp.quo});
            3'd4: pz_d = (dz_q[31] ^ dq_q[31]) ? pz_q - $signed({5'b0, div_rsp.quo})
                                               : pz_q + $signed({5'b0, div_rsp.quo});
            default: srr_d = srr_q;
          endcase
          if (((step_q == 3'd3) || (step_q == 3'd4)) && div_rsp.big) begin
            state_d = StOut;
          end else if (step_q == 3'd4) begin
            cnt_d   = cnt_q + 4'd1;
            k_d     = k_q + 4'd1;
            state_d = StNSel;
          end else begin
            step_d  = step_q + 3'd1;
            state_d = StDiv;
          end
        end
      end
      StDet: begin
        det_d = det_c;
        nr_d  = mprod_q[2] - mprod_q[3];
        nz_d  = mprod_q[4] - mprod_q[5];
        if (det_c == 64'sd0) begin
          state_d = StOut;
        end else begin
          step_d  = '0;
          state_d = StGDiv;
        end
      end
      StGDiv: begin
        state_d = StGDivW;
      end
      StGDivW: begin
        if (div_rsp.done) begin
          if (div_rsp.big) begin
            state_d = StOut;
          end else if (!step_q[0]) begin
            gr_d    = gneg ? -$signed(gq) : $signed(gq);
            step_d  = 3'd1;
            state_d = StGDiv;
          end else begin
            gz_d    = gneg ? -$signed(gq) : $signed(gq);
            ok_d    = 1'b1;
            state_d = StOut;
          end
        end
      end
      StOut: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          ograd_r_d   = ok_q ? gr_q : '0;
          ograd_z_d   = ok_q ? gz_q : '0;
          oavail_d    = ok_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= CfgW'(MaxRows);
      grid_cols_q <= CfgW'(MaxCols);
      state_q     <= StIdle;
      k_q         <= '0;
      step_q      <= '0;
      fin_q       <= 1'b0;
      cnt_q       <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      grid_rows_q <= grid_rows_d;
      grid_cols_q <= grid_cols_d;
      state_q     <= state_d;
      k_q         <= k_d;
      step_q      <= step_d;
      fin_q       <= fin_d;
      cnt_q       <= cnt_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    col_q     <= col_d;
    rc_q      <= rc_d;
    zc_q      <= zc_d;
    vc_q      <= vc_d;
    flagc_q   <= flagc_d;
    dr_q      <= dr_d;
    dz_q      <= dz_d;
    dq_q      <= dq_d;
    mprod_q   <= mprod_d;
    d2_q      <= d2_d;
    srr_q     <= srr_d;
    szz_q     <= szz_d;
    srz_q     <= srz_d;
    pr_q      <= pr_d;
    pz_q      <= pz_d;
    det_q     <= det_d;
    nr_q      <= nr_d;
    nz_q      <= nz_d;
    gr_q      <= gr_d;
    gz_q      <= gz_d;
    ograd_r_q <= ograd_r_d;
    ograd_z_q <= ograd_z_d;
    oavail_q  <= oavail_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.grad_r    = ograd_r_q;
  assign out_o.grad_z    = ograd_z_q;
  assign out_o.available = oavail_q;

  a_busy_after_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.action == ActCompute)) |=> !in_i.ready)
    else $error("request taken while a compute is in flight");

  a_zero_when_unavailable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.available) |-> (out_o.grad_r == '0) && (out_o.grad_z == '0))
    else $error("unavailable result carries a nonzero gradient");

  a_div_not_restarted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'd8)
    else $error("neighbor count above eight");
endmodule

@@ design/gws_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module gws_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ design/gws_mul.sv @@
`timescale 1ns / 1ps
// Shared unsigned multiplier, 32 by 35 bits, registered product.
module gws_mul (
  input  logic                      clk_i,
  input  logic [gws_pkg::DataW-1:0] a_i,
  input  logic [gws_pkg::MulBW-1:0] b_i,
  output logic [63:0]               p_o
);
  import gws_pkg::*;

  logic [63:0]      lo;
  logic [MulBW-1:0] hi;
  logic [66:0]      sum;
  logic [63:0]      p_q;

  always_comb begin
    lo  = {32'b0, a_i} * {32'b0, b_i[DataW-1:0]};
    hi  = ({3'b0, a_i} & {MulBW{b_i[DataW]}}) +
          ({2'b0, a_i, 1'b0} & {MulBW{b_i[DataW+1]}}) +
          ({1'b0, a_i, 2'b0} & {MulBW{b_i[DataW+2]}});
    sum = {3'b0, lo} + {hi, 32'b0};
  end

  always_ff @(posedge clk_i) begin
    p_q <= sum[63:0];
  end

  assign p_o = p_q;
endmodule

@@ design/gws_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle, for floor(num * 2^16 / den).
module gws_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gws_pkg::div_req_t req_i,
  output gws_pkg::div_rsp_t rsp_o
);
  import gws_pkg::*;

  localparam int unsigned CntW = $clog2(DivBits + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [63:0]     rem_q;
  logic [31:0]     low_q;
  logic [31:0]     quo_q;
  logic [63:0]     den_q;
  logic            ovf_q;
  logic [64:0]     trial;
  logic [64:0]     diff;
  logic            ge;

  always_comb begin
    trial = {rem_q, low_q[31]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivBits);
    end else if (busy_q) begin
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {16'b0, req_i.num[63:16]};
      low_q <= {req_i.num[15:0], 16'b0};
      quo_q <= '0;
      den_q <= req_i.den;
      ovf_q <= {16'b0, req_i.num[63:16]} >= req_i.den;
    end else if (busy_q) begin
      rem_q <= ge ? diff[63:0] : trial[63:0];
      low_q <= {low_q[30:0], 1'b0};
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.big  = ovf_q | quo_q[31];
  assign rsp_o.quo  = quo_q[30:0];
endmodule
